// ===== rtl/core/tcw_pkg.sv =====
// Package for the text console writer: operation codes, newline code, blank cell
// values, cell width and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    // operation codes carried in the func field
    localparam logic [1:0] FUNC_PUT   = 2'd0;
    localparam logic [1:0] FUNC_CLEAR = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] BLANK_CHAR   = 8'h20;
    localparam logic [3:0] BLANK_COLOR  = 4'hF;

    localparam int CELL_W = 12;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_PUT    = 6'b000010,
        S_READ   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_FILL   = 6'b010000,
        S_RESP   = 6'b100000
    } t_state;

endpackage

// ===== rtl/core/text_console_writer.sv =====
// Text console writer top level: cell memory, cursor and the sequencer that
// drives one address counter for fills and scroll copies. Depends on tcw_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                  Payload
// request   in         i_in_valid / o_in_ready    func, char_code, fg_color, read_row/col
// result    out        o_out_valid / i_out_ready  cursor_row/col, cell_char/color, scrolled
//
// Sequence: a put passes S_PUT then S_RESP, a read S_READ then S_RESP, and an
//   unused code goes straight to S_RESP. A put that scrolls adds S_SCROLL, which
//   copies every row up one, and S_FILL, which blanks the bottom row; a clear
//   blanks every cell in S_FILL. All writes share the single memory write port.
// Reset: after reset a clearing pass writes blanks to all ROWS*COLUMNS cells,
//   one a cycle, and no request is taken until it ends.
// Stalls: a finished result waits in the output register; the next request
//   is taken meanwhile and its result holds in S_RESP until the register frees.

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // request channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_char_code,
    input  logic [3:0] i_fg_color,
    input  logic [4:0] i_read_row,
    input  logic [6:0] i_read_col,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [4:0] o_cursor_row,
    output logic [6:0] o_cursor_col,
    output logic [7:0] o_cell_char,
    output logic [3:0] o_cell_color,
    output logic       o_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int PW    = AW + 6;

    localparam logic [AW-1:0] LAST_CELL    = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_STRIDE   = AW'(COLUMNS);
    localparam logic [AW-1:0] BOTTOM_BASE  = AW'(CELLS - COLUMNS);
    localparam logic [RW-1:0] LAST_ROW     = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL     = CW'(COLUMNS - 1);

    // cell memory: char in [7:0], colour in [11:8]
    logic [tcw_pkg::CELL_W-1:0] r_mem [CELLS];
    logic [tcw_pkg::CELL_W-1:0] r_rd_data;

    tcw_pkg::t_state r_state, n_state;

    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;
    logic [AW-1:0] r_row_base, n_row_base;   // r_row * COLUMNS
    logic [AW-1:0] r_cur_addr, n_cur_addr;   // r_row_base + r_col
    logic [AW-1:0] r_addr, n_addr;           // shared sweep counter
    logic [AW-1:0] r_wr_addr;                // destination of a pending copy
    logic          r_copy_vld;
    logic          r_fill_resp, n_fill_resp;

    // latched request
    logic          r_nl;
    logic [7:0]    r_ch;
    logic [3:0]    r_fg;
    logic          r_rd_ok;

    // pending result fields
    logic [7:0]    r_cell_char, n_cell_char;
    logic [3:0]    r_cell_color, n_cell_color;
    logic          r_scr, n_scr;

    // output register
    logic          r_out_valid;
    logic [4:0]    r_o_row;
    logic [6:0]    r_o_col;
    logic [7:0]    r_o_char;
    logic [3:0]    r_o_color;
    logic          r_o_scr;

    logic          in_acc;
    logic          out_load;
    logic [PW-1:0] req_addr;
    logic          req_ok;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [tcw_pkg::CELL_W-1:0] wr_data;

    assign o_in_ready = (r_state == tcw_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_load   = (r_state == tcw_pkg::S_RESP) && (!r_out_valid || i_out_ready);

    // linear address of the cell to read back and its range check
    assign req_addr = PW'(i_read_row) * PW'(COLUMNS) + PW'(i_read_col);
    assign req_ok   = (32'(i_read_row) < ROWS) && (32'(i_read_col) < COLUMNS);

    // read port: scroll source while copying, else the requested cell
    assign rd_addr = (r_state == tcw_pkg::S_SCROLL) ? r_addr : req_addr[AW-1:0];

    // write port: a pending copy wins, then blanks, then the put character
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cur_addr;
        wr_data = {r_fg, r_ch};
        if (r_copy_vld) begin
            wr_en   = 1'b1;
            wr_addr = r_wr_addr;
            wr_data = r_rd_data;
        end else if (r_state == tcw_pkg::S_FILL) begin
            wr_en   = 1'b1;
            wr_addr = r_addr;
            wr_data = {tcw_pkg::BLANK_COLOR, tcw_pkg::BLANK_CHAR};
        end else if (r_state == tcw_pkg::S_PUT) begin
            wr_en   = !r_nl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_col        = r_col;
        n_row_base   = r_row_base;
        n_cur_addr   = r_cur_addr;
        n_addr       = r_addr;
        n_fill_resp  = r_fill_resp;
        n_cell_char  = r_cell_char;
        n_cell_color = r_cell_color;
        n_scr        = r_scr;
        unique case (r_state)
            tcw_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_cell_char  = '0;
                    n_cell_color = '0;
                    n_scr        = 1'b0;
                    unique case (i_func)
                        tcw_pkg::FUNC_PUT:   n_state = tcw_pkg::S_PUT;
                        tcw_pkg::FUNC_READ:  n_state = tcw_pkg::S_READ;
                        tcw_pkg::FUNC_CLEAR: begin
                            // home the cursor and blank the whole store
                            n_row       = '0;
                            n_col       = '0;
                            n_row_base  = '0;
                            n_cur_addr  = '0;
                            n_addr      = '0;
                            n_fill_resp = 1'b1;
                            n_state     = tcw_pkg::S_FILL;
                        end
                        default:             n_state = tcw_pkg::S_RESP;
                    endcase
                end
            end
            tcw_pkg::S_PUT: begin
                if (r_nl || (r_col == LAST_COL)) begin
                    n_col = '0;
                    if (r_row == LAST_ROW) begin
                        // cursor stays on the bottom row, contents move up
                        n_cur_addr = r_row_base;
                        n_scr      = 1'b1;
                        n_addr     = ROW_STRIDE;
                        n_state    = tcw_pkg::S_SCROLL;
                    end else begin
                        n_row      = r_row + 1'b1;
                        n_row_base = r_row_base + ROW_STRIDE;
                        n_cur_addr = r_row_base + ROW_STRIDE;
                        n_state    = tcw_pkg::S_RESP;
                    end
                end else begin
                    n_col      = r_col + 1'b1;
                    n_cur_addr = r_cur_addr + 1'b1;
                    n_state    = tcw_pkg::S_RESP;
                end
            end
            tcw_pkg::S_READ: begin
                if (r_rd_ok) begin
                    n_cell_char  = r_rd_data[7:0];
                    n_cell_color = r_rd_data[11:8];
                end
                n_state = tcw_pkg::S_RESP;
            end
            tcw_pkg::S_SCROLL: begin
                // one source read a cycle; its write lands the next cycle
                if (r_addr == LAST_CELL) begin
                    n_addr      = BOTTOM_BASE;
                    n_fill_resp = 1'b1;
                    n_state     = tcw_pkg::S_FILL;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            tcw_pkg::S_FILL: begin
                // hold while the last scroll copy drains through the write port
                if (!r_copy_vld) begin
                    if (r_addr == LAST_CELL) begin
                        n_state = r_fill_resp ? tcw_pkg::S_RESP : tcw_pkg::S_IDLE;
                    end else begin
                        n_addr = r_addr + 1'b1;
                    end
                end
            end
            tcw_pkg::S_RESP: begin
                if (out_load) begin
                    n_state = tcw_pkg::S_IDLE;
                end
            end
            default: n_state = tcw_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_FILL;
            r_row       <= '0;
            r_col       <= '0;
            r_row_base  <= '0;
            r_cur_addr  <= '0;
            r_addr      <= '0;
            r_fill_resp <= 1'b0;
            r_copy_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_row_base  <= n_row_base;
            r_cur_addr  <= n_cur_addr;
            r_addr      <= n_addr;
            r_fill_resp <= n_fill_resp;
            r_copy_vld  <= (r_state == tcw_pkg::S_SCROLL);
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wr_addr    <= r_addr - ROW_STRIDE;
        r_cell_char  <= n_cell_char;
        r_cell_color <= n_cell_color;
        r_scr        <= n_scr;
        if (in_acc) begin
            r_nl    <= (i_char_code == tcw_pkg::NEWLINE_CODE);
            r_ch    <= i_char_code;
            r_fg    <= i_fg_color;
            r_rd_ok <= req_ok;
        end
        if (out_load) begin
            r_o_row   <= 5'(r_row);
            r_o_col   <= 7'(r_col);
            r_o_char  <= r_cell_char;
            r_o_color <= r_cell_color;
            r_o_scr   <= r_scr;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_cell_char  = r_o_char;
    assign o_cell_color = r_o_color;
    assign o_scrolled   = r_o_scr;

    // cursor stays on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_row) < ROWS) && (32'(r_col) < COLUMNS))
        else $error("cursor left the screen");

    // tracked linear address agrees with row and column
    a_addr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_addr == r_row_base + AW'(r_col)) && (r_row_base == AW'(r_row * COLUMNS)))
        else $error("cursor address out of step");

    // a copy write only follows a scroll read
    a_copy_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_copy_vld |-> (r_state == tcw_pkg::S_SCROLL) || (r_state == tcw_pkg::S_FILL))
        else $error("copy write outside a scroll");

    // a scrolling put leaves the cursor at column 0 of the bottom row
    a_scroll_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_scrolled) |-> (o_cursor_row == 5'(ROWS - 1)) && (o_cursor_col == '0))
        else $error("scroll result with wrong cursor");

endmodule
